// ===== src/swhs_pkg.sv =====
// Package for the single-wire humidity sensor reader.
// Holds the item types, configuration register map, phase codes and sizes.
// No dependencies.
`default_nettype none

package swhs_pkg;

    localparam int NUM_BYTES  = 5;
    localparam int DATA_W     = NUM_BYTES * 8;
    localparam int BIT_CNT_W  = $clog2(DATA_W + 1);
    localparam logic [BIT_CNT_W-1:0] BITS_TOTAL = BIT_CNT_W'(DATA_W);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_START_LOW_TICKS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE_TICKS   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ONE_THRESHOLD   = 2'd2;

    localparam logic [15:0] RST_START_LOW_TICKS = 16'd4000;
    localparam logic [7:0]  RST_RELEASE_TICKS   = 8'd80;
    localparam logic [7:0]  RST_ONE_THRESHOLD   = 8'd100;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_START_LOW = 8'b0000_0010,
        PH_RELEASE   = 8'b0000_0100,
        PH_RESP_A    = 8'b0000_1000,
        PH_RESP_B    = 8'b0001_0000,
        PH_RESP_C    = 8'b0010_0000,
        PH_BIT_LOW   = 8'b0100_0000,
        PH_BIT_HIGH  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic operation;
        logic line_level;
    } t_in_item;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic        checksum_ok;
    } t_out_item;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  one_threshold;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/swhs_cfg.sv =====
// Configuration register bank with an APB-style port.
// Uses swhs_pkg for the register map, reset values and the t_cfg bundle.
`default_nettype none

module swhs_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [swhs_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [swhs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [swhs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output swhs_pkg::t_cfg                          o_cfg
);

    swhs_pkg::t_cfg                         r_cfg;
    logic [swhs_pkg::REG_IDX_W-1:0]         reg_idx;
    logic                                   wr_en;

    assign reg_idx = paddr[swhs_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_ticks <= swhs_pkg::RST_START_LOW_TICKS;
            r_cfg.release_ticks   <= swhs_pkg::RST_RELEASE_TICKS;
            r_cfg.one_threshold   <= swhs_pkg::RST_ONE_THRESHOLD;
        end else if (wr_en) begin
            unique case (reg_idx)
                swhs_pkg::REG_START_LOW_TICKS: r_cfg.start_low_ticks <= pwdata[15:0];
                swhs_pkg::REG_RELEASE_TICKS:   r_cfg.release_ticks   <= pwdata[7:0];
                swhs_pkg::REG_ONE_THRESHOLD:   r_cfg.one_threshold   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            swhs_pkg::REG_START_LOW_TICKS: prdata = {16'd0, r_cfg.start_low_ticks};
            swhs_pkg::REG_RELEASE_TICKS:   prdata = {24'd0, r_cfg.release_ticks};
            swhs_pkg::REG_ONE_THRESHOLD:   prdata = {24'd0, r_cfg.one_threshold};
            default:                       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/swhs_core.sv =====
// Read sequencer: phase state, tick and pulse timers, bit shifter and result decode.
// Advances by one item whenever enabled. Uses swhs_pkg.
`default_nettype none

module swhs_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_enable,
    input  wire swhs_pkg::t_in_item  i_item,
    input  wire swhs_pkg::t_cfg      i_cfg,
    output swhs_pkg::t_out_item      o_result
);

    swhs_pkg::t_phase                   r_phase, n_phase;
    logic [15:0]                        r_tick_count, n_tick_count;
    logic [7:0]                         r_high_time, n_high_time;
    logic [swhs_pkg::BIT_CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [swhs_pkg::DATA_W-1:0]        r_shift_data, n_shift_data;

    logic        done;
    logic        bit_val;
    logic [15:0] tick_inc;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic [9:0]  byte_sum;

    assign tick_inc = r_tick_count + 16'd1;
    assign bit_val  = r_high_time > i_cfg.one_threshold;

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_high_time  = r_high_time;
        n_bit_count  = r_bit_count;
        n_shift_data = r_shift_data;
        done         = 1'b0;
        if (i_item.operation == swhs_pkg::OP_START) begin
            n_phase      = swhs_pkg::PH_START_LOW;
            n_tick_count = '0;
            n_high_time  = '0;
            n_bit_count  = '0;
            n_shift_data = '0;
        end else begin
            unique case (r_phase)
                swhs_pkg::PH_IDLE: ;
                swhs_pkg::PH_START_LOW: begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= i_cfg.start_low_ticks) begin
                        n_phase      = swhs_pkg::PH_RELEASE;
                        n_tick_count = '0;
                    end
                end
                swhs_pkg::PH_RELEASE: begin
                    n_tick_count = tick_inc;
                    if (tick_inc >= {8'd0, i_cfg.release_ticks}) begin
                        n_phase      = swhs_pkg::PH_RESP_A;
                        n_tick_count = '0;
                    end
                end
                swhs_pkg::PH_RESP_A: begin
                    if (!i_item.line_level) n_phase = swhs_pkg::PH_RESP_B;
                end
                swhs_pkg::PH_RESP_B: begin
                    if (i_item.line_level) n_phase = swhs_pkg::PH_RESP_C;
                end
                swhs_pkg::PH_RESP_C: begin
                    if (!i_item.line_level) n_phase = swhs_pkg::PH_BIT_LOW;
                end
                swhs_pkg::PH_BIT_LOW: begin
                    if (i_item.line_level) begin
                        n_high_time = '0;
                        n_phase     = swhs_pkg::PH_BIT_HIGH;
                    end
                end
                swhs_pkg::PH_BIT_HIGH: begin
                    if (i_item.line_level) begin
                        if (r_high_time != 8'hFF) n_high_time = r_high_time + 8'd1;
                    end else begin
                        n_shift_data = {r_shift_data[swhs_pkg::DATA_W-2:0], bit_val};
                        n_bit_count  = r_bit_count + 1'b1;
                        if (n_bit_count >= swhs_pkg::BITS_TOTAL) begin
                            done    = 1'b1;
                            n_phase = swhs_pkg::PH_IDLE;
                        end else begin
                            n_phase = swhs_pkg::PH_BIT_LOW;
                        end
                    end
                end
                default: n_phase = swhs_pkg::PH_IDLE;
            endcase
        end
    end

    assign b0       = n_shift_data[39:32];
    assign b1       = n_shift_data[31:24];
    assign b2       = n_shift_data[23:16];
    assign b3       = n_shift_data[15:8];
    assign b4       = n_shift_data[7:0];
    assign byte_sum = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};

    always_comb begin
        o_result.drive_low   = n_phase == swhs_pkg::PH_START_LOW;
        o_result.busy_res    = n_phase != swhs_pkg::PH_IDLE;
        o_result.done_res    = done;
        o_result.humidity    = done ? {b0, b1} : 16'd0;
        o_result.temperature = done ? {b2, b3} : 16'd0;
        o_result.checksum_ok = done && (byte_sum[7:0] == b4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= swhs_pkg::PH_IDLE;
            r_tick_count <= '0;
            r_high_time  <= '0;
            r_bit_count  <= '0;
            r_shift_data <= '0;
        end else if (i_enable) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_high_time  <= n_high_time;
            r_bit_count  <= n_bit_count;
            r_shift_data <= n_shift_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/single_wire_humidity_sensor_reader.sv =====
// Top level of the single-wire humidity and temperature sensor reader.
// Instantiates swhs_cfg and swhs_core; uses swhs_pkg for types and codes.
// One item is taken every clock cycle while results are taken: the item is registered, the
// phase update is computed from it, and the result is captured in an output register. A
// result that is not taken holds the input register and so stalls the input. Each item is
// either one sampling tick of the data line or a start command, and yields exactly one
// result that shows whether the line is being pulled low, whether a read is in progress and,
// on the tick that completes the fortieth bit, the humidity, temperature and checksum status.
// There is no timeout: a sensor that never answers leaves the block busy until the next start.
`default_nettype none

module single_wire_humidity_sensor_reader (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire swhs_pkg::t_in_item                 i_in_item,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output swhs_pkg::t_out_item                     o_out_item,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [swhs_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [swhs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [swhs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    swhs_pkg::t_cfg         cfg;
    swhs_pkg::t_out_item    result;
    logic                   advance;

    logic                   r_in_valid;
    swhs_pkg::t_in_item     r_in_item;
    logic                   r_out_valid;
    swhs_pkg::t_out_item    r_out_item;

    swhs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    swhs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    a_drive_implies_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.drive_low |-> o_out_item.busy_res
    ) else $error("Line driven low on a result that is not busy.");

    a_done_not_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.done_res |-> !o_out_item.busy_res && !o_out_item.drive_low
    ) else $error("Completed read still reports busy.");

    a_data_only_on_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.done_res |->
            o_out_item.humidity == 16'd0 && o_out_item.temperature == 16'd0 &&
            !o_out_item.checksum_ok
    ) else $error("Read data shown on a result that is not done.");

    a_stalled_item_kept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_item)
    ) else $error("Registered item lost while the result register was full.");

endmodule

`default_nettype wire
